>>> rtl/tlc_pkg.sv
// Shared types and constants for the text line-numbering and caret filter.
// Holds the port word structs, the front-to-back job struct and the back phase enum.
// No dependencies.
package tlc_pkg;

  // Input word: one raw text byte plus the start-of-file flag.
  typedef struct packed {
    logic [7:0] in_byte;
    logic       first_of_file;
  } in_t;

  // Output word: one formatted byte plus the end-of-run marker.
  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_of_run;
  } out_t;

  // Configuration registers.
  typedef struct packed {
    logic [1:0] number_mode;
    logic       squeeze_blank;
    logic       show_ends;
    logic       show_nonprinting;
    logic       show_tabs;
  } cfg_t;

  // Classified job handed from the front to the back (line number travels beside it).
  typedef struct packed {
    logic       num_en;
    logic       dollar;
    logic       caret;
    logic [7:0] tail_byte;
  } job_t;

  // Back sequencer phases.
  typedef enum logic [2:0] {
    PH_DIGIT,
    PH_TAB,
    PH_DOLLAR,
    PH_CARET,
    PH_BYTE
  } phase_e;

  // Configuration port.
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 8;

  localparam logic [CfgIdxW-1:0] REG_NUMBER_MODE      = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_SQUEEZE_BLANK    = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_SHOW_ENDS        = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_SHOW_NONPRINTING = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_SHOW_TABS        = 3'd4;

  // Numbering modes (any other code means no numbering).
  localparam logic [1:0] NUM_ALL      = 2'd1;
  localparam logic [1:0] NUM_NONEMPTY = 2'd2;

  // Characters.
  localparam logic [7:0] CH_TAB    = 8'd9;
  localparam logic [7:0] CH_NL     = 8'd10;
  localparam logic [7:0] CH_SPACE  = 8'd32;
  localparam logic [7:0] CH_DOLLAR = 8'd36;
  localparam logic [7:0] CH_ZERO   = 8'd48;
  localparam logic [7:0] CH_QMARK  = 8'd63;
  localparam logic [7:0] CH_CAP_I  = 8'd73;
  localparam logic [7:0] CH_CARET  = 8'd94;
  localparam logic [7:0] CH_DEL    = 8'd127;
  localparam logic [7:0] CTRL_END  = 8'd32;
  localparam logic [7:0] CARET_OFS = 8'd64;

  localparam logic [3:0] DIGIT_NINE = 4'd9;

  // Saturation limit of the blank-line run count.
  localparam logic [1:0] RUN_MAX = 2'd2;

endpackage

>>> rtl/tlc_fifo.sv
// Small synchronous queue with push/full and pop/empty sides.
// Used between front and back and as the output stage. No package dependency.
module tlc_fifo #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [Width-1:0] data_o,
  output logic             empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]  cnt_q;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

endmodule

>>> rtl/tlc_front.sv
// Front part: accepts text bytes, keeps line state and the BCD line counter,
// drops squeezed lines and classifies each byte into a job. Uses tlc_pkg.
module tlc_front #(
  parameter int unsigned NumDigits = 6
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  tlc_pkg::cfg_t          cfg_i,
  input  logic                   push_i,
  input  tlc_pkg::in_t           in_data_i,
  output logic                   full_o,
  input  logic                   job_full_i,
  output logic                   job_push_o,
  output tlc_pkg::job_t          job_o,
  output logic [4*NumDigits-1:0] digits_o
);

  localparam int unsigned CntW = 4 * NumDigits;

  logic [CntW-1:0]    cnt_q, cnt_d, cnt0, cnt_bump;
  logic               als_q, als_d;
  logic [1:0]         run_q, run_d, run0;
  logic [NumDigits:0] carry;
  logic               accept, line_start, is_nl, is_ctrl, drop, number;
  logic [7:0]         b;
  logic [3:0]         d;

  assign full_o = job_full_i;
  assign accept = push_i && !job_full_i;

  always_comb begin
    b          = in_data_i.in_byte;
    is_nl      = (b == tlc_pkg::CH_NL);
    line_start = in_data_i.first_of_file || als_q;
    run0       = in_data_i.first_of_file ? 2'd0 : run_q;
    cnt0       = in_data_i.first_of_file ? '0 : cnt_q;

    // Saturating BCD increment: a digit moves when all lower digits are nine.
    carry[0] = 1'b1;
    cnt_bump = cnt0;
    for (int i = 0; i < NumDigits; i++) begin
      d            = cnt0[4*i +: 4];
      carry[i+1]   = carry[i] && (d >= tlc_pkg::DIGIT_NINE);
      if (carry[i]) begin
        cnt_bump[4*i +: 4] = (d >= tlc_pkg::DIGIT_NINE) ? 4'd0 : d + 4'd1;
      end
    end
    if (carry[NumDigits]) begin
      cnt_bump = cnt0;
    end

    run_d = run0;
    if (line_start && cfg_i.squeeze_blank) begin
      if (is_nl) begin
        run_d = (run0 >= tlc_pkg::RUN_MAX) ? tlc_pkg::RUN_MAX : run0 + 2'd1;
      end else begin
        run_d = 2'd0;
      end
    end
    drop = line_start && cfg_i.squeeze_blank && (run_d >= tlc_pkg::RUN_MAX);

    // A dropped line is never numbered and never advances the counter.
    number = line_start && !drop && ((cfg_i.number_mode == tlc_pkg::NUM_ALL) ||
             ((cfg_i.number_mode == tlc_pkg::NUM_NONEMPTY) && !is_nl));
    cnt_d  = number ? cnt_bump : cnt0;
    als_d  = drop ? 1'b1 : is_nl;

    is_ctrl = (b < tlc_pkg::CTRL_END) && !is_nl && (b != tlc_pkg::CH_TAB);

    job_o.num_en    = number;
    job_o.dollar    = cfg_i.show_ends && is_nl;
    job_o.caret     = 1'b0;
    job_o.tail_byte = b;
    if (cfg_i.show_nonprinting && (b == tlc_pkg::CH_DEL)) begin
      job_o.caret     = 1'b1;
      job_o.tail_byte = tlc_pkg::CH_QMARK;
    end else if (cfg_i.show_nonprinting && is_ctrl) begin
      job_o.caret     = 1'b1;
      job_o.tail_byte = b + tlc_pkg::CARET_OFS;
    end else if (cfg_i.show_tabs && (b == tlc_pkg::CH_TAB)) begin
      job_o.caret     = 1'b1;
      job_o.tail_byte = tlc_pkg::CH_CAP_I;
    end
  end

  assign job_push_o = accept && !drop;
  assign digits_o   = cnt_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      als_q <= 1'b1;
      run_q <= 2'd0;
    end else if (accept) begin
      cnt_q <= cnt_d;
      als_q <= als_d;
      run_q <= run_d;
    end
  end

endmodule

>>> rtl/tlc_back.sv
// Back part: walks the head job through its phases and emits one output word
// per cycle into the output queue while a job waits and the queue has room. Uses tlc_pkg.
module tlc_back #(
  parameter int unsigned NumDigits = 6
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   job_valid_i,
  input  tlc_pkg::job_t          job_i,
  input  logic [4*NumDigits-1:0] digits_i,
  output logic                   job_pop_o,
  input  logic                   out_full_i,
  output logic                   out_push_o,
  output tlc_pkg::out_t          out_word_o
);

  localparam int unsigned IdxW = (NumDigits > 1) ? $clog2(NumDigits) : 1;

  tlc_pkg::phase_e  phase_q, phase_d, phase, nxt, after_num, after_dollar;
  logic             started_q, started_d;
  logic [IdxW-1:0]  idx_q, idx_d, idx, idx_nxt;
  logic [3:0]       dig [NumDigits];
  logic [NumDigits-1:0] seen;
  logic             emit, last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= tlc_pkg::PH_BYTE;
      started_q <= 1'b0;
      idx_q     <= '0;
    end else begin
      phase_q   <= phase_d;
      started_q <= started_d;
      idx_q     <= idx_d;
    end
  end

  always_comb begin
    // Leading blanks: a digit shows once it or any higher digit is nonzero; the lowest digit always shows.
    for (int i = NumDigits - 1; i >= 0; i--) begin
      dig[i]  = digits_i[4*i +: 4];
      seen[i] = (dig[i] != 4'd0) || (i == 0) ||
                ((i < NumDigits - 1) ? seen[(i+1) % NumDigits] : 1'b0);
    end

    after_dollar = job_i.caret ? tlc_pkg::PH_CARET : tlc_pkg::PH_BYTE;
    after_num    = job_i.dollar ? tlc_pkg::PH_DOLLAR : after_dollar;
    phase        = started_q ? phase_q
                 : (job_i.num_en ? tlc_pkg::PH_DIGIT : after_num);
    idx          = started_q ? idx_q : IdxW'(NumDigits - 1);
    emit         = job_valid_i && !out_full_i;

    idx_nxt  = idx;
    last     = 1'b0;
    out_word_o.out_byte = job_i.tail_byte;
    case (phase)
      tlc_pkg::PH_DIGIT: begin
        out_word_o.out_byte = seen[idx] ? tlc_pkg::CH_ZERO + {4'd0, dig[idx]}
                                        : tlc_pkg::CH_SPACE;
        nxt     = (idx == '0) ? tlc_pkg::PH_TAB : tlc_pkg::PH_DIGIT;
        idx_nxt = idx - IdxW'(1);
      end
      tlc_pkg::PH_TAB: begin
        out_word_o.out_byte = tlc_pkg::CH_TAB;
        nxt = after_num;
      end
      tlc_pkg::PH_DOLLAR: begin
        out_word_o.out_byte = tlc_pkg::CH_DOLLAR;
        nxt = after_dollar;
      end
      tlc_pkg::PH_CARET: begin
        out_word_o.out_byte = tlc_pkg::CH_CARET;
        nxt = tlc_pkg::PH_BYTE;
      end
      default: begin
        last = 1'b1;
        nxt  = tlc_pkg::PH_BYTE;
      end
    endcase
    out_word_o.last_of_run = last;

    phase_d   = phase_q;
    started_d = started_q;
    idx_d     = idx_q;
    if (emit) begin
      phase_d   = nxt;
      started_d = !last;
      idx_d     = idx_nxt;
    end
  end

  assign out_push_o = emit;
  assign job_pop_o  = emit && last;

endmodule

>>> rtl/text_line_number_and_caret_filter_core.sv
// Top level of the text line-numbering and caret filter: config registers,
// front, job queue, back and output queue. Uses tlc_pkg, tlc_front, tlc_back, tlc_fifo.
//
// The block takes one text byte per accepted input word and emits its formatted
// bytes as output words, the final one of each run flagged by last_of_run. A byte
// that needs no prefix gives a single output word, so plain text streams at one
// byte per clock while the output queue has room. A byte that opens a numbered
// line, or that gets '$' or caret notation, gives up to NUMBER_DIGITS+3 output
// words (9 at the default), which the back sequencer emits one word per clock
// while the output queue has room; meanwhile the front keeps accepting bytes
// until the two-entry job queue fills. A squeezed blank line is accepted and
// produces nothing. The first output word of a byte passes through the job
// queue and then the output queue before it reaches the ports.
// The line counter is BCD and saturates at all nines.
// Configuration writes are always ready and must only be issued while idle.
module text_line_number_and_caret_filter_core #(
  parameter int unsigned NUMBER_DIGITS = 6
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // configuration write channel
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [tlc_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [tlc_pkg::CfgDataW-1:0]   cfg_data_i,
  // input byte queue side
  input  logic                           push,
  output logic                           full,
  input  tlc_pkg::in_t                   in_data_i,
  // output word queue side
  output logic                           empty,
  input  logic                           pop,
  output tlc_pkg::out_t                  out_data_o
);

  localparam int unsigned DigW = 4 * NUMBER_DIGITS;
  localparam int unsigned JobW = $bits(tlc_pkg::job_t) + DigW;

  tlc_pkg::cfg_t   cfg_q;
  tlc_pkg::job_t   front_job, head_job;
  logic [DigW-1:0] front_digits, head_digits;
  logic            job_push, job_full, job_pop, job_empty;
  logic            out_push, out_full;
  tlc_pkg::out_t   out_word;

  // Config registers: writes to unknown indexes are dropped.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        tlc_pkg::REG_NUMBER_MODE:      cfg_q.number_mode      <= cfg_data_i[1:0];
        tlc_pkg::REG_SQUEEZE_BLANK:    cfg_q.squeeze_blank    <= cfg_data_i[0];
        tlc_pkg::REG_SHOW_ENDS:        cfg_q.show_ends        <= cfg_data_i[0];
        tlc_pkg::REG_SHOW_NONPRINTING: cfg_q.show_nonprinting <= cfg_data_i[0];
        tlc_pkg::REG_SHOW_TABS:        cfg_q.show_tabs        <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Front: line state, counter, squeeze and classification.
  tlc_front #(
    .NumDigits (NUMBER_DIGITS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .push_i     (push),
    .in_data_i  (in_data_i),
    .full_o     (full),
    .job_full_i (job_full),
    .job_push_o (job_push),
    .job_o      (front_job),
    .digits_o   (front_digits)
  );

  // Job queue: decouples the front from the back sequencer.
  tlc_fifo #(
    .Width (JobW),
    .Depth (2)
  ) u_job_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (job_push),
    .data_i  ({front_job, front_digits}),
    .full_o  (job_full),
    .pop_i   (job_pop),
    .data_o  ({head_job, head_digits}),
    .empty_o (job_empty)
  );

  // Back: expand each job into its output words.
  tlc_back #(
    .NumDigits (NUMBER_DIGITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (!job_empty),
    .job_i       (head_job),
    .digits_i    (head_digits),
    .job_pop_o   (job_pop),
    .out_full_i  (out_full),
    .out_push_o  (out_push),
    .out_word_o  (out_word)
  );

  // Output queue: holds up to two finished words so the back does not wait on every pop.
  tlc_fifo #(
    .Width ($bits(tlc_pkg::out_t)),
    .Depth (2)
  ) u_out_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (out_push),
    .data_i  (out_word),
    .full_o  (out_full),
    .pop_i   (pop),
    .data_o  (out_data_o),
    .empty_o (empty)
  );

  // A job leaves the queue only with the word that ends its run.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_pop |-> (out_push && out_word.last_of_run))
    else $error("job popped without its final word");

  // After a word that does not end a run, the job is still at the queue head.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_push && !out_word.last_of_run) |=> !job_empty)
    else $error("job lost in the middle of its run");

  // Prefix words are never a newline.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_push && !out_word.last_of_run) |-> (out_word.out_byte != tlc_pkg::CH_NL))
    else $error("newline emitted as a prefix word");

endmodule
